/* sv/mwmff_pkg.sv */
package mwmff_pkg;

    localparam int MAX_CELLS_ACROSS = 64;
    localparam int MAX_CELLS_DOWN   = 64;

    localparam int GRID_W    = 2 * MAX_CELLS_ACROSS + 1;
    localparam int GRID_H    = 2 * MAX_CELLS_DOWN + 1;
    localparam int GRID_SIZE = GRID_W * GRID_H;
    localparam int ADDR_W    = $clog2(GRID_SIZE + 1);
    localparam int COORD_W   = $clog2(((GRID_W > GRID_H) ? GRID_W : GRID_H) + 2);
    localparam int STK_W     = 2 * COORD_W;
    localparam int VAL_W     = 13;
    localparam int CFG_W     = 7;

    localparam logic [VAL_W-1:0] COUNT_MAX = '1;
    localparam logic [VAL_W-1:0] WALL      = '1;

    // request codes
    localparam logic [1:0] REQ_INIT    = 2'd0;
    localparam logic [1:0] REQ_PROPOSE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_EAST  = 2'd3;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [ADDR_W-1:0]  t_addr;

    // flat grid address with a fixed row stride
    function automatic t_addr grid_addr(input t_coord x, input t_coord y);
        logic [ADDR_W+COORD_W-1:0] a;
        a = (ADDR_W+COORD_W)'(y) * (ADDR_W+COORD_W)'(GRID_W) + (ADDR_W+COORD_W)'(x);
        return a[ADDR_W-1:0];
    endfunction

    // clamp a written size to 1..max
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] r;
        r = v;
        if (r == '0) r = CFG_W'(1);
        if (r > maxv) r = maxv;
        return r;
    endfunction

endpackage

/* sv/mwmff_ram.sv */
module mwmff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* sv/maze_wall_merge_flood_fill.sv */
// one transaction at a time, steps from accept to the next accept:
// init sweeps the whole grid store (GRID_SIZE entries)
// proposal: reads both labels and compares them; a cell outside the grid goes to the result
//   directly; a merge writes the wall, then pops each position and checks its neighbours
// read: address then data in range, directly to the result outside; other requests likewise
// synchronous active-low reset clears control, sets the zero count to one and sizes to 64 x 64
module maze_wall_merge_flood_fill (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_cell_col,
    input  logic [5:0]  i_cell_row,
    input  logic [1:0]  i_direction,
    input  logic [7:0]  i_grid_col,
    input  logic [7:0]  i_grid_row,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic signed [12:0] o_entry_value,
    output logic [12:0] o_zero_cells,
    output logic        o_complete,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_ARD  = 4'd2;
    localparam logic [3:0] S_BRD  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_POP  = 4'd5;
    localparam logic [3:0] S_POPW = 4'd6;
    localparam logic [3:0] S_NB   = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_RDRQ = 4'd9;
    localparam logic [3:0] S_RDDT = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam int CW = mwmff_pkg::COORD_W;
    localparam int AW = mwmff_pkg::ADDR_W;
    localparam int VW = mwmff_pkg::VAL_W;
    localparam int FW = mwmff_pkg::CFG_W;

    logic [3:0]    r_state;
    logic [FW-1:0] r_across, r_down;
    logic [VW-1:0] r_zero;
    logic [CW-1:0] r_x, r_y, r_xp, r_yp, r_cx, r_cy, r_nx, r_ny;
    logic [VW-1:0] r_v, r_a, r_k;
    logic [AW-1:0] r_top, r_iaddr;
    logic [1:0]    r_dir;
    logic          r_res_acc;
    logic [VW-1:0] r_res_entry;
    logic          r_out_valid, r_out_acc, r_out_complete;
    logic [VW-1:0] r_out_entry, r_out_zero;

    logic          g_we, s_we;
    logic [AW-1:0] g_waddr, g_raddr;
    logic [VW-1:0] g_wdata, g_rdata;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [mwmff_pkg::STK_W-1:0] s_wdata, s_rdata;

    logic [CW-1:0] w, h;
    logic          in_acc, out_take, cfg_wr, out_load;

    assign w = CW'({r_across, 1'b1});
    assign h = CW'({r_down, 1'b1});
    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_take = r_out_valid && !i_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign cfg_wr   = psel && penable && pwrite;
    assign o_stall  = (r_state != S_IDLE);

    mwmff_ram #(.WIDTH(VW), .DEPTH(mwmff_pkg::GRID_SIZE)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata)
    );

    mwmff_ram #(.WIDTH(mwmff_pkg::STK_W), .DEPTH(mwmff_pkg::GRID_SIZE)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2]) prdata[FW-1:0] = r_down;
        else          prdata[FW-1:0] = r_across;
    end

    // init sweep position
    logic [CW-1:0] ix, iy;
    logic          i_cell;
    always_comb begin
        ix = '0;
        iy = '0;
        i_cell = 1'b0;
        ix = r_x;
        iy = r_y;
        i_cell = (ix < w) && (iy < h) && ix[0] && iy[0];
    end

    // proposed cell and its neighbour, a missing neighbour is the cell itself
    logic [CW-1:0] p_x, p_y, p_xp, p_yp;
    always_comb begin
        p_x  = CW'({i_cell_col, 1'b1});
        p_y  = CW'({i_cell_row, 1'b1});
        p_xp = p_x;
        p_yp = p_y;
        case (i_direction)
            mwmff_pkg::DIR_NORTH: if (i_cell_row != '0) p_yp = p_y - CW'(2);
            mwmff_pkg::DIR_SOUTH:
                if ((CW+1)'(p_y) + (CW+1)'(2) < (CW+1)'(h)) p_yp = p_y + CW'(2);
            mwmff_pkg::DIR_WEST: if (i_cell_col != '0) p_xp = p_x - CW'(2);
            default:
                if ((CW+1)'(p_x) + (CW+1)'(2) < (CW+1)'(w)) p_xp = p_x + CW'(2);
        endcase
    end

    // flood neighbour in the current direction
    logic [CW:0]   nx_w, ny_w;
    logic          nb_ok;
    always_comb begin
        nx_w  = {1'b0, r_cx};
        ny_w  = {1'b0, r_cy};
        nb_ok = 1'b0;
        case (r_dir)
            2'd0: begin
                nx_w  = {1'b0, r_cx} + 1'b1;
                nb_ok = nx_w < {1'b0, w};
            end
            2'd1: begin
                nx_w  = {1'b0, r_cx} - 1'b1;
                nb_ok = r_cx != '0;
            end
            2'd2: begin
                ny_w  = {1'b0, r_cy} + 1'b1;
                nb_ok = ny_w < {1'b0, h};
            end
            default: begin
                ny_w  = {1'b0, r_cy} - 1'b1;
                nb_ok = r_cy != '0;
            end
        endcase
    end

    // wall between proposed cell and its neighbour
    logic [CW-1:0] wx, wy;
    logic [CW:0]   sx, sy;
    always_comb begin
        sx = {1'b0, r_x} + {1'b0, r_xp};
        sy = {1'b0, r_y} + {1'b0, r_yp};
        wx = sx[CW:1];
        wy = sy[CW:1];
    end

    logic [VW-1:0] b_val, min_v;
    logic          lt_chk;
    assign b_val  = g_rdata;
    assign min_v  = ($signed(r_a) < $signed(b_val)) ? r_a : b_val;
    assign lt_chk = $signed(r_v) < $signed(g_rdata);

    // memory port control
    always_comb begin
        g_we    = 1'b0;
        g_waddr = mwmff_pkg::grid_addr(wx, wy);
        g_wdata = min_v;
        g_raddr = mwmff_pkg::grid_addr(r_x, r_y);
        s_we    = 1'b0;
        s_waddr = r_top;
        s_wdata = {wy, wx};
        s_raddr = r_top - 1'b1;
        case (r_state)
            S_INIT: begin
                g_we    = 1'b1;
                g_waddr = r_iaddr;
                g_wdata = i_cell ? r_k : mwmff_pkg::WALL;
            end
            S_BRD: g_raddr = mwmff_pkg::grid_addr(r_xp, r_yp);
            S_CMP: begin
                g_we = (r_a != b_val);
                s_we = (r_a != b_val);
            end
            S_NB: g_raddr = mwmff_pkg::grid_addr(nx_w[CW-1:0], ny_w[CW-1:0]);
            S_CHK: begin
                g_we    = lt_chk;
                g_waddr = mwmff_pkg::grid_addr(r_nx, r_ny);
                g_wdata = r_v;
                s_we    = lt_chk;
                s_wdata = {r_ny, r_nx};
            end
            default: ;
        endcase
    end

    logic [2*FW-1:0] total;
    assign total = r_across * r_down;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_across    <= FW'(mwmff_pkg::MAX_CELLS_ACROSS);
            r_down      <= FW'(mwmff_pkg::MAX_CELLS_DOWN);
            r_zero      <= VW'(1);
            r_out_valid <= 1'b0;
            r_top       <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_down <= mwmff_pkg::clamp_cfg(pwdata[FW-1:0],
                                                   FW'(mwmff_pkg::MAX_CELLS_DOWN));
                end else begin
                    r_across <= mwmff_pkg::clamp_cfg(pwdata[FW-1:0],
                                                     FW'(mwmff_pkg::MAX_CELLS_ACROSS));
                end
            end
            // result register occupancy
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_acc <= 1'b0;
                        case (i_req_type)
                            mwmff_pkg::REQ_INIT: begin
                                r_x         <= '0;
                                r_y         <= '0;
                                r_iaddr     <= '0;
                                r_k         <= '0;
                                r_res_entry <= '0;
                                r_state     <= S_INIT;
                            end
                            mwmff_pkg::REQ_PROPOSE: begin
                                r_x         <= p_x;
                                r_y         <= p_y;
                                r_xp        <= p_xp;
                                r_yp        <= p_yp;
                                r_res_entry <= '0;
                                if (FW'(i_cell_col) < r_across && FW'(i_cell_row) < r_down)
                                    r_state <= S_ARD;
                                else
                                    r_state <= S_DONE;
                            end
                            mwmff_pkg::REQ_READ: begin
                                r_x <= i_grid_col;
                                r_y <= i_grid_row;
                                if (i_grid_col < w && i_grid_row < h) begin
                                    r_res_entry <= '0;
                                    r_state     <= S_RDRQ;
                                end else begin
                                    r_res_entry <= mwmff_pkg::WALL;
                                    r_state     <= S_DONE;
                                end
                            end
                            default: begin
                                r_res_entry <= '0;
                                r_state     <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    if (i_cell) r_k <= r_k + 1'b1;
                    r_iaddr <= r_iaddr + 1'b1;
                    if (r_x == CW'(mwmff_pkg::GRID_W - 1)) begin
                        r_x <= '0;
                        r_y <= r_y + 1'b1;
                        if (r_y == CW'(mwmff_pkg::GRID_H - 1)) begin
                            r_zero  <= VW'(1);
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_ARD: r_state <= S_BRD;
                S_BRD: begin
                    r_a     <= g_rdata;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_a == b_val) begin
                        r_state <= S_DONE;
                    end else begin
                        r_v   <= min_v;
                        r_top <= AW'(1);
                        if (min_v == '0 && wx[0] && wy[0] && r_zero != mwmff_pkg::COUNT_MAX)
                            r_zero <= r_zero + 1'b1;
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_top == '0) begin
                        r_res_acc <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_top   <= r_top - 1'b1;
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    r_cx    <= s_rdata[CW-1:0];
                    r_cy    <= s_rdata[2*CW-1:CW];
                    r_dir   <= '0;
                    r_state <= S_NB;
                end
                S_NB: begin
                    r_nx <= nx_w[CW-1:0];
                    r_ny <= ny_w[CW-1:0];
                    if (nb_ok) begin
                        r_state <= S_CHK;
                    end else if (r_dir == 2'd3) begin
                        r_state <= S_POP;
                    end else begin
                        r_dir <= r_dir + 1'b1;
                    end
                end
                S_CHK: begin
                    if (lt_chk) begin
                        r_top <= r_top + 1'b1;
                        if (r_v == '0 && r_nx[0] && r_ny[0] &&
                            r_zero != mwmff_pkg::COUNT_MAX)
                            r_zero <= r_zero + 1'b1;
                    end
                    if (r_dir == 2'd3) begin
                        r_state <= S_POP;
                    end else begin
                        r_dir   <= r_dir + 1'b1;
                        r_state <= S_NB;
                    end
                end
                S_RDRQ: r_state <= S_RDDT;
                S_RDDT: begin
                    r_res_entry <= g_rdata;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_acc      <= r_res_acc;
            r_out_entry    <= r_res_entry;
            r_out_zero     <= r_zero;
            r_out_complete <= ({1'b0, r_zero} >= total);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_accepted    = r_out_acc;
    assign o_entry_value = $signed(r_out_entry);
    assign o_zero_cells  = r_out_zero;
    assign o_complete    = r_out_complete;
endmodule

/* sv/mwmff_checker.sv */
module mwmff_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_accepted,
    input logic [12:0] o_zero_cells,
    input logic        o_complete
);
    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // every transaction keeps the input stalled in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after transaction");

    // a held result does not change
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_accepted)
            && $stable(o_zero_cells) && $stable(o_complete))
        else $error("stalled result changed");

    // a complete maze always has at least one zero cell
    a_complete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_complete |-> o_zero_cells != 13'd0)
        else $error("complete with zero count of zero");
endmodule

bind maze_wall_merge_flood_fill mwmff_checker u_mwmff_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_accepted(o_accepted),
    .o_zero_cells(o_zero_cells), .o_complete(o_complete)
);
